// File: hw/rtl/ecb_pkg.sv
// ----------------------------------------------------------------------------
// ecb_pkg
// Shared constants, types and the arctangent table of the camera basis block.
// ----------------------------------------------------------------------------
package ecb_pkg;

   localparam int ANGLE_FRAC_BITS = 16;
   localparam int VEC_FRAC_BITS   = 14;
   localparam int TRIG_ITERATIONS = 16;

   localparam int WF        = 24;
   localparam int ANGLE_W   = 25;
   localparam int VEC_W     = 27;
   localparam int OUT_W     = 16;
   localparam int CSR_W     = 16;
   localparam int SUMSQ_W   = 52;
   localparam int PROD_W    = 2 * VEC_W;
   localparam int CORDIC_W  = 33;
   localparam int Z_W       = 34;
   localparam int CORDIC_STEPS = (TRIG_ITERATIONS < 24) ? TRIG_ITERATIONS : 24;
   localparam int STEP_W    = $clog2(CORDIC_STEPS);

   localparam logic CMD_ROTATE = 1'b0;
   localparam logic CMD_SET    = 1'b1;

   typedef logic signed [VEC_W-1:0] comp_type;
   typedef comp_type [2:0] vec_type;

   typedef enum logic [1:0] {
      CSR_SENS,
      CSR_UP_X,
      CSR_UP_Y,
      CSR_UP_Z
   } csr_index_type;

   typedef enum logic [3:0] {
      T_IDLE,
      T_DELTA,
      T_ANGLE,
      T_TRIG_Y,
      T_TRIG_P,
      T_FRONT,
      T_SQR,
      T_NORM,
      T_CROSS,
      T_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      N_IDLE,
      N_ROOT,
      N_LOAD,
      N_DIV,
      N_DONE
   } norm_state_type;

   typedef struct packed {
      logic                        start;
      logic signed [ANGLE_W-1:0]   angle;
   } trig_req_type;

   typedef struct packed {
      logic     done;
      comp_type sin_v;
      comp_type cos_v;
   } trig_rsp_type;

   typedef struct packed {
      logic               start;
      logic [SUMSQ_W-1:0] sumsq;
      vec_type            vec;
   } norm_req_type;

   typedef struct packed {
      logic    done;
      vec_type vec;
   } norm_rsp_type;

   // atan(2^-i) in degrees, 24 fraction bits
   function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] i);
      logic signed [Z_W-1:0] r;
      case (i)
         5'd0:    r = 34'sd754974720;
         5'd1:    r = 34'sd445687602;
         5'd2:    r = 34'sd235489088;
         5'd3:    r = 34'sd119537938;
         5'd4:    r = 34'sd60000934;
         5'd5:    r = 34'sd30029717;
         5'd6:    r = 34'sd15018523;
         5'd7:    r = 34'sd7509720;
         5'd8:    r = 34'sd3754917;
         5'd9:    r = 34'sd1877466;
         5'd10:   r = 34'sd938734;
         5'd11:   r = 34'sd469367;
         5'd12:   r = 34'sd234684;
         5'd13:   r = 34'sd117342;
         5'd14:   r = 34'sd58671;
         5'd15:   r = 34'sd29335;
         5'd16:   r = 34'sd14668;
         5'd17:   r = 34'sd7334;
         5'd18:   r = 34'sd3667;
         5'd19:   r = 34'sd1833;
         5'd20:   r = 34'sd917;
         5'd21:   r = 34'sd458;
         5'd22:   r = 34'sd229;
         5'd23:   r = 34'sd115;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/euler_camera_basis_top.sv
// ----------------------------------------------------------------------------
// euler_camera_basis_top
// First-person camera basis from yaw and pitch: front, right and up vectors.
// ----------------------------------------------------------------------------
// One transaction at a time: a request is taken only while the block is idle. Two CORDIC
// passes of 16 steps give the trig terms; one shared 27x27 multiplier serves the
// delta scaling, the front vector, both cross products and the squared lengths; the three
// normalizations dominate, each a 26-step square root and three 26-step
// restoring divisions. A finished response sits in the output register while
// the next request is taken.
module euler_camera_basis_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [15:0]                  req_x_delta,
   input  logic signed [15:0]                  req_y_delta,
   input  logic                                req_clamp_pitch,
   input  logic signed [ecb_pkg::ANGLE_W-1:0]  req_new_yaw,
   input  logic signed [ecb_pkg::ANGLE_W-1:0]  req_new_pitch,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_front_x,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_front_y,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_front_z,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_right_x,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_right_y,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_right_z,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_up_x,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_up_y,
   output logic signed [ecb_pkg::OUT_W-1:0]    rsp_up_z,
   output logic signed [ecb_pkg::ANGLE_W-1:0]  rsp_yaw_now,
   output logic signed [ecb_pkg::ANGLE_W-1:0]  rsp_pitch_now,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [ecb_pkg::CSR_W-1:0]           csr_wdata
);

   localparam int VW = ecb_pkg::VEC_W;
   localparam int PW = ecb_pkg::PROD_W;
   localparam int AW = 28;
   localparam int DSHIFT = 24 - ecb_pkg::ANGLE_FRAC_BITS;
   localparam int USHIFT = ecb_pkg::WF - ecb_pkg::VEC_FRAC_BITS;
   localparam logic signed [AW-1:0] FULL = 28'sd360 <<< ecb_pkg::ANGLE_FRAC_BITS;
   localparam logic signed [AW-1:0] HALF = 28'sd180 <<< ecb_pkg::ANGLE_FRAC_BITS;
   localparam logic signed [AW-1:0] LIM  = 28'sd89 <<< ecb_pkg::ANGLE_FRAC_BITS;
   localparam logic signed [PW-1:0] DHALF = 54'sd1 <<< (DSHIFT - 1);
   localparam logic signed [PW:0]   VHALF = 55'sd1 <<< (ecb_pkg::WF - 1);

   function automatic logic signed [ecb_pkg::ANGLE_W-1:0] wrap(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] r;
      r = v;
      if (v >= HALF) r = v - FULL;
      else if (v < -HALF) r = v + FULL;
      return ecb_pkg::ANGLE_W'(r);
   endfunction

   function automatic logic [ecb_pkg::OUT_W-1:0] to_out(input ecb_pkg::comp_type v);
      logic [VW-1:0] m, r;
      m = v[VW-1] ? VW'(-v) : VW'(v);
      r = (m + (VW'(1) << (USHIFT - 1))) >> USHIFT;
      if (r > (VW'(1) << ecb_pkg::VEC_FRAC_BITS)) r = VW'(1) << ecb_pkg::VEC_FRAC_BITS;
      if (v[VW-1]) r = -r;
      return r[ecb_pkg::OUT_W-1:0];
   endfunction

   function automatic ecb_pkg::comp_type rshr_v(input logic signed [PW:0] p);
      logic signed [PW:0] s;
      s = (p + VHALF) >>> ecb_pkg::WF;
      return VW'(s);
   endfunction

   ecb_pkg::top_state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [1:0]  phase_ff, phase_in;

   logic [ecb_pkg::CSR_W-1:0]        sens_ff;
   logic signed [ecb_pkg::CSR_W-1:0] wu_ff [3];

   logic                                cmd_ff, cmd_in, clamp_ff, clamp_in;
   logic signed [15:0]                  xd_ff, xd_in, yd_ff, yd_in;
   logic signed [ecb_pkg::ANGLE_W-1:0]  ny_ff, ny_in, np_ff, np_in;
   logic signed [ecb_pkg::ANGLE_W-1:0]  yaw_ff, yaw_in, pitch_ff, pitch_in;
   ecb_pkg::comp_type                   dx_ff, dx_in, dy_ff, dy_in;
   ecb_pkg::comp_type                   cy_ff, cy_in, sy_ff, sy_in, cp_ff, cp_in, sp_ff, sp_in;
   ecb_pkg::comp_type                   vec_ff [3];
   ecb_pkg::comp_type                   vec_in [3];
   ecb_pkg::comp_type                   f_ff [3];
   ecb_pkg::comp_type                   f_in [3];
   ecb_pkg::comp_type                   r_ff [3];
   ecb_pkg::comp_type                   r_in [3];
   ecb_pkg::comp_type                   u_ff [3];
   ecb_pkg::comp_type                   u_in [3];
   ecb_pkg::comp_type                   wus [3];
   ecb_pkg::comp_type                   ca [3];
   ecb_pkg::comp_type                   cb [3];
   logic [ecb_pkg::SUMSQ_W-1:0]         sq_ff, sq_in;
   logic signed [PW-1:0]                xacc_ff, xacc_in;
   logic signed [PW-1:0]                prod_ff;
   ecb_pkg::comp_type                   mul_a, mul_b;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ecb_pkg::OUT_W-1:0]           vout_ff [9];
   logic [ecb_pkg::OUT_W-1:0]           vout_in [9];
   logic signed [ecb_pkg::ANGLE_W-1:0]  ryaw_ff, ryaw_in, rpitch_ff, rpitch_in;

   logic signed [AW-1:0]                ysum, psum;
   logic signed [PW-1:0]                dsh;

   ecb_pkg::trig_req_type trig_req;
   ecb_pkg::trig_rsp_type trig_rsp;
   ecb_pkg::norm_req_type norm_req;
   ecb_pkg::norm_rsp_type norm_rsp;

   ecb_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .trig_req (trig_req),
      .trig_rsp (trig_rsp)
   );

   ecb_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .norm_req (norm_req),
      .norm_rsp (norm_rsp)
   );

   assign req_stall = (state_ff != ecb_pkg::T_IDLE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wus[i] = VW'(wu_ff[i]) <<< USHIFT;
         ca[i] = (phase_ff == 2'd1) ? f_ff[i] : r_ff[i];
         cb[i] = (phase_ff == 2'd1) ? wus[i] : f_ff[i];
      end
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ecb_pkg::T_DELTA: begin
            mul_a = (cnt_ff == 3'd0) ? VW'(xd_ff) : VW'(yd_ff);
            mul_b = $signed({{(VW - ecb_pkg::CSR_W){1'b0}}, sens_ff});
         end
         ecb_pkg::T_FRONT: begin
            mul_a = (cnt_ff == 3'd0) ? cy_ff : sy_ff;
            mul_b = cp_ff;
         end
         ecb_pkg::T_SQR: begin
            if (cnt_ff < 3'd3) begin
               mul_a = vec_ff[cnt_ff[1:0]];
               mul_b = vec_ff[cnt_ff[1:0]];
            end
         end
         ecb_pkg::T_CROSS: begin
            case (cnt_ff)
               3'd0: begin mul_a = ca[1]; mul_b = cb[2]; end
               3'd1: begin mul_a = ca[2]; mul_b = cb[1]; end
               3'd2: begin mul_a = ca[2]; mul_b = cb[0]; end
               3'd3: begin mul_a = ca[0]; mul_b = cb[2]; end
               3'd4: begin mul_a = ca[0]; mul_b = cb[1]; end
               3'd5: begin mul_a = ca[1]; mul_b = cb[0]; end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff + 1'b1;
      phase_in = phase_ff;
      cmd_in = cmd_ff;
      clamp_in = clamp_ff;
      xd_in = xd_ff;
      yd_in = yd_ff;
      ny_in = ny_ff;
      np_in = np_ff;
      yaw_in = yaw_ff;
      pitch_in = pitch_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      cy_in = cy_ff;
      sy_in = sy_ff;
      cp_in = cp_ff;
      sp_in = sp_ff;
      vec_in = vec_ff;
      f_in = f_ff;
      r_in = r_ff;
      u_in = u_ff;
      sq_in = sq_ff;
      xacc_in = xacc_ff;
      vout_in = vout_ff;
      ryaw_in = ryaw_ff;
      rpitch_in = rpitch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      trig_req.start = 1'b0;
      trig_req.angle = (state_ff == ecb_pkg::T_TRIG_P) ? pitch_ff : yaw_ff;
      norm_req.start = 1'b0;
      norm_req.sumsq = sq_ff;
      norm_req.vec[0] = vec_ff[0];
      norm_req.vec[1] = vec_ff[1];
      norm_req.vec[2] = vec_ff[2];
      dsh = (prod_ff + DHALF) >>> DSHIFT;
      ysum = AW'(yaw_ff) + AW'(dx_ff);
      psum = AW'(pitch_ff) + AW'(dy_ff);
      if (clamp_ff) begin
         if (psum > LIM) psum = LIM;
         if (psum < -LIM) psum = -LIM;
      end
      unique case (state_ff)
         ecb_pkg::T_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd_in = req_cmd;
               clamp_in = req_clamp_pitch;
               xd_in = req_x_delta;
               yd_in = req_y_delta;
               ny_in = req_new_yaw;
               np_in = req_new_pitch;
               state_in = req_cmd ? ecb_pkg::T_ANGLE : ecb_pkg::T_DELTA;
            end
         end
         ecb_pkg::T_DELTA: begin
            if (cnt_ff == 3'd1) dx_in = VW'(dsh);
            if (cnt_ff == 3'd2) begin
               dy_in = VW'(dsh);
               state_in = ecb_pkg::T_ANGLE;
            end
         end
         ecb_pkg::T_ANGLE: begin
            if (cmd_ff) begin
               yaw_in = wrap(AW'(ny_ff));
               pitch_in = wrap(AW'(np_ff));
            end else begin
               yaw_in = wrap(ysum);
               pitch_in = wrap(psum);
            end
            cnt_in = '0;
            state_in = ecb_pkg::T_TRIG_Y;
         end
         ecb_pkg::T_TRIG_Y: begin
            trig_req.start = (cnt_ff == 3'd0);
            cnt_in = 3'd1;
            if (trig_rsp.done) begin
               cy_in = trig_rsp.cos_v;
               sy_in = trig_rsp.sin_v;
               cnt_in = '0;
               state_in = ecb_pkg::T_TRIG_P;
            end
         end
         ecb_pkg::T_TRIG_P: begin
            trig_req.start = (cnt_ff == 3'd0);
            cnt_in = 3'd1;
            if (trig_rsp.done) begin
               cp_in = trig_rsp.cos_v;
               sp_in = trig_rsp.sin_v;
               cnt_in = '0;
               state_in = ecb_pkg::T_FRONT;
            end
         end
         ecb_pkg::T_FRONT: begin
            if (cnt_ff == 3'd1) vec_in[0] = rshr_v(PW'(prod_ff) + (PW+1)'(0));
            if (cnt_ff == 3'd2) begin
               vec_in[2] = rshr_v((PW+1)'(prod_ff));
               vec_in[1] = sp_ff;
               phase_in = 2'd0;
               cnt_in = '0;
               state_in = ecb_pkg::T_SQR;
            end
         end
         ecb_pkg::T_SQR: begin
            if (cnt_ff == 3'd1) sq_in = prod_ff[ecb_pkg::SUMSQ_W-1:0];
            if (cnt_ff == 3'd2 || cnt_ff == 3'd3) begin
               sq_in = sq_ff + prod_ff[ecb_pkg::SUMSQ_W-1:0];
            end
            if (cnt_ff == 3'd3) begin
               cnt_in = '0;
               state_in = ecb_pkg::T_NORM;
            end
         end
         ecb_pkg::T_NORM: begin
            norm_req.start = (cnt_ff == 3'd0);
            cnt_in = 3'd1;
            if (norm_rsp.done) begin
               cnt_in = '0;
               for (int i = 0; i < 3; i++) begin
                  case (phase_ff)
                     2'd0: f_in[i] = $signed(norm_rsp.vec[i]);
                     2'd1: r_in[i] = $signed(norm_rsp.vec[i]);
                     default: u_in[i] = $signed(norm_rsp.vec[i]);
                  endcase
               end
               if (phase_ff == 2'd2) begin
                  state_in = ecb_pkg::T_OUT;
               end else begin
                  phase_in = phase_ff + 1'b1;
                  state_in = ecb_pkg::T_CROSS;
               end
            end
         end
         ecb_pkg::T_CROSS: begin
            case (cnt_ff)
               3'd1, 3'd3, 3'd5: xacc_in = prod_ff;
               3'd2: vec_in[0] = rshr_v((PW+1)'(xacc_ff) - (PW+1)'(prod_ff));
               3'd4: vec_in[1] = rshr_v((PW+1)'(xacc_ff) - (PW+1)'(prod_ff));
               3'd6: vec_in[2] = rshr_v((PW+1)'(xacc_ff) - (PW+1)'(prod_ff));
               default: xacc_in = xacc_ff;
            endcase
            if (cnt_ff == 3'd6) begin
               cnt_in = '0;
               state_in = ecb_pkg::T_SQR;
            end
         end
         ecb_pkg::T_OUT: begin
            cnt_in = '0;
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int i = 0; i < 3; i++) begin
                  vout_in[i] = to_out(f_ff[i]);
                  vout_in[3 + i] = to_out(r_ff[i]);
                  vout_in[6 + i] = to_out(u_ff[i]);
               end
               ryaw_in = yaw_ff;
               rpitch_in = pitch_ff;
               rsp_valid_in = 1'b1;
               state_in = ecb_pkg::T_IDLE;
            end
         end
         default: state_in = ecb_pkg::T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ecb_pkg::T_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         yaw_ff       <= -(25'sd90 <<< ecb_pkg::ANGLE_FRAC_BITS);
         pitch_ff     <= '0;
         sens_ff      <= 16'd6554;
         wu_ff[0]     <= '0;
         wu_ff[1]     <= 16'sd1 <<< ecb_pkg::VEC_FRAC_BITS;
         wu_ff[2]     <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         yaw_ff       <= yaw_in;
         pitch_ff     <= pitch_in;
         if (csr_we) begin
            unique case (ecb_pkg::csr_index_type'(csr_index))
               ecb_pkg::CSR_SENS: sens_ff  <= csr_wdata;
               ecb_pkg::CSR_UP_X: wu_ff[0] <= $signed(csr_wdata);
               ecb_pkg::CSR_UP_Y: wu_ff[1] <= $signed(csr_wdata);
               ecb_pkg::CSR_UP_Z: wu_ff[2] <= $signed(csr_wdata);
               default: sens_ff <= sens_ff;
            endcase
         end
      end
      cmd_ff    <= cmd_in;
      clamp_ff  <= clamp_in;
      xd_ff     <= xd_in;
      yd_ff     <= yd_in;
      ny_ff     <= ny_in;
      np_ff     <= np_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      cy_ff     <= cy_in;
      sy_ff     <= sy_in;
      cp_ff     <= cp_in;
      sp_ff     <= sp_in;
      vec_ff    <= vec_in;
      f_ff      <= f_in;
      r_ff      <= r_in;
      u_ff      <= u_in;
      sq_ff     <= sq_in;
      xacc_ff   <= xacc_in;
      prod_ff   <= mul_a * mul_b;
      vout_ff   <= vout_in;
      ryaw_ff   <= ryaw_in;
      rpitch_ff <= rpitch_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_front_x   = $signed(vout_ff[0]);
   assign rsp_front_y   = $signed(vout_ff[1]);
   assign rsp_front_z   = $signed(vout_ff[2]);
   assign rsp_right_x   = $signed(vout_ff[3]);
   assign rsp_right_y   = $signed(vout_ff[4]);
   assign rsp_right_z   = $signed(vout_ff[5]);
   assign rsp_up_x      = $signed(vout_ff[6]);
   assign rsp_up_y      = $signed(vout_ff[7]);
   assign rsp_up_z      = $signed(vout_ff[8]);
   assign rsp_yaw_now   = ryaw_ff;
   assign rsp_pitch_now = rpitch_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != ecb_pkg::T_IDLE))
      else $error("accepted transaction did not start");

   a_trig_done_in_trig: assert property (@(posedge clock) disable iff (reset)
      trig_rsp.done |-> (state_ff == ecb_pkg::T_TRIG_Y || state_ff == ecb_pkg::T_TRIG_P))
      else $error("trig result outside trig phase");

   a_norm_done_in_norm: assert property (@(posedge clock) disable iff (reset)
      norm_rsp.done |-> (state_ff == ecb_pkg::T_NORM))
      else $error("normalizer result outside norm phase");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ecb_pkg::T_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == ecb_pkg::T_OUT))
      else $error("response overwritten while stalled");

endmodule

// File: hw/rtl/ecb_cordic.sv
// ----------------------------------------------------------------------------
// ecb_cordic
// Iterative rotation CORDIC: sine and cosine of an angle in degrees.
// ----------------------------------------------------------------------------
module ecb_cordic (
   input  logic                 clock,
   input  logic                 reset,
   input  ecb_pkg::trig_req_type trig_req,
   output ecb_pkg::trig_rsp_type trig_rsp
);

   localparam int ZSHIFT = 24 - ecb_pkg::ANGLE_FRAC_BITS;
   localparam int RSHIFT = 30 - ecb_pkg::WF;
   localparam logic signed [ecb_pkg::Z_W-1:0] D90  = 34'sd90 <<< 24;
   localparam logic signed [ecb_pkg::Z_W-1:0] D180 = 34'sd180 <<< 24;
   localparam logic signed [ecb_pkg::CORDIC_W-1:0] GAIN = 33'sd652032874;
   localparam logic signed [ecb_pkg::CORDIC_W-1:0] RHALF = 33'sd1 <<< (RSHIFT - 1);

   logic signed [ecb_pkg::CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ecb_pkg::Z_W-1:0]      z_ff, z_in;
   logic                                neg_ff, neg_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [ecb_pkg::STEP_W-1:0]          cnt_ff, cnt_in;

   logic signed [ecb_pkg::Z_W-1:0]      z0;
   logic signed [ecb_pkg::CORDIC_W-1:0] xs, ys, xr, yr;

   always_comb begin
      z0 = $signed({{(ecb_pkg::Z_W - ecb_pkg::ANGLE_W){trig_req.angle[ecb_pkg::ANGLE_W-1]}},
                    trig_req.angle}) <<< ZSHIFT;
      xs = x_ff >>> cnt_ff;
      ys = y_ff >>> cnt_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      neg_in = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      if (trig_req.start) begin
         x_in = GAIN;
         y_in = '0;
         neg_in = 1'b0;
         z_in = z0;
         if (z0 > D90) begin
            z_in = z0 - D180;
            neg_in = 1'b1;
         end else if (z0 < -D90) begin
            z_in = z0 + D180;
            neg_in = 1'b1;
         end
         busy_in = 1'b1;
         cnt_in = '0;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ecb_pkg::atan_deg(5'(cnt_ff));
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ecb_pkg::atan_deg(5'(cnt_ff));
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ecb_pkg::STEP_W'(ecb_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      xr = (x_ff + RHALF) >>> RSHIFT;
      yr = (y_ff + RHALF) >>> RSHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
   end

   assign trig_rsp.done  = done_ff;
   assign trig_rsp.cos_v = neg_ff ? -ecb_pkg::VEC_W'(xr) : ecb_pkg::VEC_W'(xr);
   assign trig_rsp.sin_v = neg_ff ? -ecb_pkg::VEC_W'(yr) : ecb_pkg::VEC_W'(yr);

endmodule

// File: hw/rtl/ecb_norm.sv
// ----------------------------------------------------------------------------
// ecb_norm
// Vector normalizer: bit-pair integer square root, then restoring division
// of each component by the root.
// ----------------------------------------------------------------------------
module ecb_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  ecb_pkg::norm_req_type norm_req,
   output ecb_pkg::norm_rsp_type norm_rsp
);

   localparam int SW = ecb_pkg::SUMSQ_W;
   localparam int VW = ecb_pkg::VEC_W;
   localparam logic [25:0] ONE = 26'd1 << ecb_pkg::WF;

   ecb_pkg::norm_state_type state_ff, state_in;
   logic [SW-1:0]     rem_ff, rem_in, root_ff, root_in;
   logic [4:0]        k_ff, k_in;
   logic [1:0]        comp_ff, comp_in;
   logic [VW-1:0]     drem_ff, drem_in;
   logic [25:0]       dnum_ff, dnum_in;
   logic [25:0]       q_ff, q_in;
   logic              neg_ff, neg_in;
   ecb_pkg::comp_type out_ff [3];
   ecb_pkg::comp_type out_in [3];

   logic [SW-1:0]     bitv, t;
   logic [VW-1:0]     n;
   ecb_pkg::comp_type vc;
   logic [VW-1:0]     m;
   logic [SW-1:0]     num;
   logic [VW:0]       r2;
   logic              ge;
   logic [25:0]       qs;

   always_comb begin
      state_in = state_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      k_in = k_ff;
      comp_in = comp_ff;
      drem_in = drem_ff;
      dnum_in = dnum_ff;
      q_in = q_ff;
      neg_in = neg_ff;
      out_in = out_ff;
      bitv = SW'(1) << {k_ff, 1'b0};
      t = root_ff + bitv;
      n = root_ff[VW-1:0];
      vc = $signed(norm_req.vec[comp_ff]);
      m = vc[VW-1] ? VW'(-vc) : VW'(vc);
      num = (SW'(m) << ecb_pkg::WF) + (root_ff >> 1);
      r2 = {drem_ff, dnum_ff[k_ff]};
      ge = r2 >= {1'b0, n};
      qs = q_ff | (26'(ge) << k_ff);
      unique case (state_ff)
         ecb_pkg::N_IDLE: begin
            if (norm_req.start) begin
               rem_in = norm_req.sumsq;
               root_in = '0;
               k_in = 5'd25;
               state_in = ecb_pkg::N_ROOT;
            end
         end
         ecb_pkg::N_ROOT: begin
            if (rem_ff >= t) begin
               rem_in = rem_ff - t;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               comp_in = '0;
               state_in = ecb_pkg::N_LOAD;
            end
         end
         ecb_pkg::N_LOAD: begin
            if (n == '0) begin
               out_in[comp_ff] = '0;
               comp_in = comp_ff + 1'b1;
               if (comp_ff == 2'd2) state_in = ecb_pkg::N_DONE;
            end else begin
               drem_in = VW'(num[SW-1:26]);
               dnum_in = num[25:0];
               q_in = '0;
               k_in = 5'd25;
               neg_in = vc[VW-1];
               state_in = ecb_pkg::N_DIV;
            end
         end
         ecb_pkg::N_DIV: begin
            drem_in = ge ? VW'(r2 - {1'b0, n}) : VW'(r2);
            q_in = qs;
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               if (qs > ONE) qs = ONE;
               out_in[comp_ff] = neg_ff ? -$signed(VW'(qs)) : $signed(VW'(qs));
               comp_in = comp_ff + 1'b1;
               state_in = (comp_ff == 2'd2) ? ecb_pkg::N_DONE : ecb_pkg::N_LOAD;
            end
         end
         ecb_pkg::N_DONE: begin
            state_in = ecb_pkg::N_IDLE;
         end
         default: state_in = ecb_pkg::N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecb_pkg::N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      k_ff    <= k_in;
      comp_ff <= comp_in;
      drem_ff <= drem_in;
      dnum_ff <= dnum_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      out_ff  <= out_in;
   end

   assign norm_rsp.done   = (state_ff == ecb_pkg::N_DONE);
   assign norm_rsp.vec[0] = out_ff[0];
   assign norm_rsp.vec[1] = out_ff[1];
   assign norm_rsp.vec[2] = out_ff[2];

endmodule

// File: tb/ecb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecb_checker
// Watches the request, response and register ports of the camera basis block,
// keeps its own model of the yaw, pitch and register state, predicts the
// front, right and up vectors for every accepted request and compares each
// accepted response against the oldest prediction.
// ----------------------------------------------------------------------------
module ecb_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_cmd,
   input  logic signed [15:0]                  req_x_delta,
   input  logic signed [15:0]                  req_y_delta,
   input  logic                                req_clamp_pitch,
   input  logic signed [ecb_pkg::ANGLE_W-1:0]  req_new_yaw,
   input  logic signed [ecb_pkg::ANGLE_W-1:0]  req_new_pitch,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_front_x,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_front_y,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_front_z,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_right_x,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_right_y,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_right_z,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_up_x,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_up_y,
   input  logic signed [ecb_pkg::OUT_W-1:0]    rsp_up_z,
   input  logic signed [ecb_pkg::ANGLE_W-1:0]  rsp_yaw_now,
   input  logic signed [ecb_pkg::ANGLE_W-1:0]  rsp_pitch_now,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [ecb_pkg::CSR_W-1:0]           csr_wdata,
   output int                                  errors,
   output int                                  pending
);

   localparam int   AF      = ecb_pkg::ANGLE_FRAC_BITS;
   localparam int   WF      = ecb_pkg::WF;
   localparam int   VF      = ecb_pkg::VEC_FRAC_BITS;
   localparam longint CORDIC_GAIN = 64'sd652032874;

   typedef logic [10:0][24:0] basis_type;

   longint    yaw_deg;
   longint    pitch_deg;
   longint    sens;
   longint    up_ref [3];
   basis_type basis_q [$];
   string     field_names [11] = '{"front_x", "front_y", "front_z", "right_x", "right_y",
      "right_z", "up_x", "up_y", "up_z", "yaw_now", "pitch_now"};

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint wrap_deg(longint v);
      longint full;
      longint half;
      longint r;
      full = 64'sd360 <<< AF;
      half = 64'sd180 <<< AF;
      r = v % full;
      if (r >= half) r = r - full;
      if (r < -half) r = r + full;
      return r;
   endfunction

   task automatic sin_cos(input longint ang, output longint s, output longint c);
      longint z;
      longint x;
      longint y;
      longint xs;
      longint ys;
      bit     flip;
      z = ang * (64'sd1 <<< (24 - AF));
      x = CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (z > (64'sd90 <<< 24)) begin
         z = z - (64'sd180 <<< 24);
         flip = 1;
      end else if (z < -(64'sd90 <<< 24)) begin
         z = z + (64'sd180 <<< 24);
         flip = 1;
      end
      for (int i = 0; i < ecb_pkg::CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ecb_pkg::atan_deg(5'(i)));
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ecb_pkg::atan_deg(5'(i)));
         end
      end
      x = round_shift(x, 30 - WF);
      y = round_shift(y, 30 - WF);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic unit_vec(input longint v [3], output longint o [3]);
      longint unsigned sq;
      longint unsigned n;
      longint unsigned m;
      longint unsigned q;
      sq = 0;
      for (int k = 0; k < 3; k++) sq = sq + longint'(v[k] * v[k]);
      n = int_sqrt(sq);
      for (int k = 0; k < 3; k++) begin
         if (n == 0) begin
            o[k] = 0;
         end else begin
            m = (v[k] < 0) ? -v[k] : v[k];
            q = ((m << WF) + n / 2) / n;
            if (q > (64'd1 << WF)) q = 64'd1 << WF;
            o[k] = (v[k] < 0) ? -longint'(q) : longint'(q);
         end
      end
   endtask

   task automatic cross3(input longint a [3], input longint b [3], output longint o [3]);
      o[0] = round_shift(a[1] * b[2] - a[2] * b[1], WF);
      o[1] = round_shift(a[2] * b[0] - a[0] * b[2], WF);
      o[2] = round_shift(a[0] * b[1] - a[1] * b[0], WF);
   endtask

   function automatic logic [24:0] out_comp(longint v);
      longint m;
      longint r;
      m = (v < 0) ? -v : v;
      r = (m + (64'sd1 <<< (WF - VF - 1))) >>> (WF - VF);
      if (r > (64'sd1 <<< VF)) r = 64'sd1 <<< VF;
      if (v < 0) r = -r;
      return {9'b0, r[15:0]};
   endfunction

   task automatic predict_basis(output basis_type res);
      longint sy, cy, sp, cp, p, lim;
      longint f0 [3], f [3], r0 [3], r [3], u0 [3], u [3], wu [3];
      if (req_cmd == ecb_pkg::CMD_SET) begin
         yaw_deg = wrap_deg(longint'(req_new_yaw));
         pitch_deg = wrap_deg(longint'(req_new_pitch));
      end else begin
         lim = 64'sd89 <<< AF;
         p = pitch_deg + round_shift(longint'(req_y_delta) * sens, 24 - AF);
         yaw_deg = wrap_deg(yaw_deg + round_shift(longint'(req_x_delta) * sens, 24 - AF));
         if (req_clamp_pitch) begin
            if (p > lim) p = lim;
            if (p < -lim) p = -lim;
         end
         pitch_deg = wrap_deg(p);
      end
      sin_cos(yaw_deg, sy, cy);
      sin_cos(pitch_deg, sp, cp);
      f0[0] = round_shift(cy * cp, WF);
      f0[1] = sp;
      f0[2] = round_shift(sy * cp, WF);
      unit_vec(f0, f);
      for (int k = 0; k < 3; k++) wu[k] = up_ref[k] * (64'sd1 <<< (WF - VF));
      cross3(f, wu, r0);
      unit_vec(r0, r);
      cross3(r, f, u0);
      unit_vec(u0, u);
      for (int k = 0; k < 3; k++) begin
         res[k] = out_comp(f[k]);
         res[3 + k] = out_comp(r[k]);
         res[6 + k] = out_comp(u[k]);
      end
      res[9] = yaw_deg[24:0];
      res[10] = pitch_deg[24:0];
   endtask

   always @(posedge clock) begin
      basis_type want;
      basis_type got;
      if (reset) begin
         yaw_deg = -(64'sd90 <<< AF);
         pitch_deg = 0;
         sens = 6554;
         up_ref[0] = 0;
         up_ref[1] = 64'sd1 <<< VF;
         up_ref[2] = 0;
      end else begin
         if (csr_we) begin
            case (ecb_pkg::csr_index_type'(csr_index))
               ecb_pkg::CSR_SENS: sens = longint'(csr_wdata);
               ecb_pkg::CSR_UP_X: up_ref[0] = longint'($signed(csr_wdata));
               ecb_pkg::CSR_UP_Y: up_ref[1] = longint'($signed(csr_wdata));
               ecb_pkg::CSR_UP_Z: up_ref[2] = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_basis(want);
            basis_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pitch_now, rsp_yaw_now, 9'b0, rsp_up_z, 9'b0, rsp_up_y, 9'b0, rsp_up_x,
               9'b0, rsp_right_z, 9'b0, rsp_right_y, 9'b0, rsp_right_x, 9'b0, rsp_front_z,
               9'b0, rsp_front_y, 9'b0, rsp_front_x};
            if (basis_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               errors++;
            end else begin
               want = basis_q.pop_front();
               for (int k = 0; k < 11; k++) begin
                  if (got[k] !== want[k]) begin
                     $error("%s: expected %h, got %h", field_names[k], want[k], got[k]);
                     errors++;
                  end
               end
            end
         end
      end
      pending <= basis_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the camera basis block with directed and random rotate and set
// requests under several register settings, with random gaps on the request
// side and random stalls on the response side; the checker does the scoring.
// ----------------------------------------------------------------------------
module testbench;

   localparam int   DEG        = 1 << ecb_pkg::ANGLE_FRAC_BITS;
   localparam int   ANG_MIN    = -11796480;
   localparam int   ANG_SPAN   = 23592959;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic                               req_cmd;
   logic signed [15:0]                 req_x_delta;
   logic signed [15:0]                 req_y_delta;
   logic                               req_clamp_pitch;
   logic signed [ecb_pkg::ANGLE_W-1:0] req_new_yaw;
   logic signed [ecb_pkg::ANGLE_W-1:0] req_new_pitch;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [ecb_pkg::OUT_W-1:0]   rsp_front_x, rsp_front_y, rsp_front_z;
   logic signed [ecb_pkg::OUT_W-1:0]   rsp_right_x, rsp_right_y, rsp_right_z;
   logic signed [ecb_pkg::OUT_W-1:0]   rsp_up_x, rsp_up_y, rsp_up_z;
   logic signed [ecb_pkg::ANGLE_W-1:0] rsp_yaw_now;
   logic signed [ecb_pkg::ANGLE_W-1:0] rsp_pitch_now;
   logic                               csr_we;
   logic [1:0]                         csr_index;
   logic [ecb_pkg::CSR_W-1:0]          csr_wdata;
   int                                 errors;
   int                                 pending;
   bit                                 quiet;
   int                                 stall_left;

   euler_camera_basis_top i_dut (.*);
   ecb_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 0;
         stall_left <= idle_len();
      end
   end

   task automatic send_req(logic c, int xd, int yd, logic cl, int ny, int np);
      int gap;
      req_cmd <= c;
      req_x_delta <= 16'(xd);
      req_y_delta <= 16'(yd);
      req_clamp_pitch <= cl;
      req_new_yaw <= ecb_pkg::ANGLE_W'(ny);
      req_new_pitch <= ecb_pkg::ANGLE_W'(np);
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
   endtask

   task automatic write_csr(ecb_pkg::csr_index_type idx, int val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= ecb_pkg::CSR_W'(val);
      @(negedge clock);
      csr_we <= 0;
   endtask

   function automatic int rand_angle();
      if ($urandom_range(0, 9) == 0) return ($urandom_range(0, 8) - 4) * 90 * DEG;
      return ANG_MIN + int'($urandom_range(0, ANG_SPAN));
   endfunction

   task automatic random_reqs(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_req(ecb_pkg::CMD_SET, $urandom, $urandom, 1'($urandom), rand_angle(),
               rand_angle());
         else
            send_req(ecb_pkg::CMD_ROTATE, $urandom, $urandom, $urandom_range(0, 3) != 0,
               rand_angle(), rand_angle());
      end
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_cmd = ecb_pkg::CMD_ROTATE;
      req_x_delta = 0;
      req_y_delta = 0;
      req_clamp_pitch = 0;
      req_new_yaw = 0;
      req_new_pitch = 0;
      rsp_stall = 0;
      stall_left = 0;
      csr_we = 0;
      csr_index = ecb_pkg::CSR_SENS;
      csr_wdata = 0;
      quiet = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: default registers
      send_req(ecb_pkg::CMD_ROTATE, 0, 0, 0, 0, 0);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 0, 0);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 11796479, 11796479);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, ANG_MIN, ANG_MIN);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 0, 90 * DEG);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 45 * DEG, -90 * DEG);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 16777215, -16777216);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 170 * DEG, 88 * DEG);
      send_req(ecb_pkg::CMD_ROTATE, 32767, 32767, 1, 0, 0);
      send_req(ecb_pkg::CMD_ROTATE, 32767, 32767, 0, 0, 0);
      send_req(ecb_pkg::CMD_ROTATE, -32768, -32768, 1, 0, 0);
      send_req(ecb_pkg::CMD_ROTATE, -32768, -32768, 1, 0, 0);
      send_req(ecb_pkg::CMD_ROTATE, -32768, -32768, 0, 0, 0);
      send_req(ecb_pkg::CMD_ROTATE, 1, -1, 0, 0, 0);
      drain();

      write_csr(ecb_pkg::CSR_SENS, 65535);
      write_csr(ecb_pkg::CSR_UP_X, -16384);
      write_csr(ecb_pkg::CSR_UP_Y, 0);
      write_csr(ecb_pkg::CSR_UP_Z, 16384);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 180 * DEG, 0);
      send_req(ecb_pkg::CMD_ROTATE, 32767, 32767, 1, 0, 0);
      send_req(ecb_pkg::CMD_ROTATE, -32768, 32767, 0, 0, 0);
      send_req(ecb_pkg::CMD_SET, 0, 0, 0, 90 * DEG, 0);
      random_reqs(200);
      drain();

      write_csr(ecb_pkg::CSR_SENS, 0);
      write_csr(ecb_pkg::CSR_UP_X, 0);
      write_csr(ecb_pkg::CSR_UP_Y, 0);
      write_csr(ecb_pkg::CSR_UP_Z, 0);
      quiet = 1;
      random_reqs(60);
      drain();
      quiet = 0;

      write_csr(ecb_pkg::CSR_SENS, 6554);
      write_csr(ecb_pkg::CSR_UP_X, 0);
      write_csr(ecb_pkg::CSR_UP_Y, -16384);
      write_csr(ecb_pkg::CSR_UP_Z, 0);
      random_reqs(200);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         write_csr(ecb_pkg::CSR_SENS, $urandom_range(0, 65535));
         write_csr(ecb_pkg::CSR_UP_X, $urandom_range(0, 32768) - 16384);
         write_csr(ecb_pkg::CSR_UP_Y, $urandom_range(0, 32768) - 16384);
         write_csr(ecb_pkg::CSR_UP_Z, $urandom_range(0, 32768) - 16384);
         quiet = (ph == 1);
         random_reqs(110);
         drain();
      end

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/ecb_pkg.sv
hw/rtl/ecb_cordic.sv
hw/rtl/ecb_norm.sv
hw/rtl/euler_camera_basis_top.sv
tb/ecb_checker.sv
tb/testbench.sv
